// ===== sv/dfa_pkg.sv =====
`default_nettype none
package dfa_pkg;

	localparam int MAX_STATES  = 64;
	localparam int SYMBOL_SPAN = 256;
	localparam int LENGTH_BITS = 16;

	localparam int STATE_BITS = $clog2(MAX_STATES);
	localparam int COL_BITS   = $clog2(SYMBOL_SPAN);
	localparam int SYM_BITS   = 8;
	localparam int ENTRY_BITS = STATE_BITS + 1;
	localparam int TRANS_DEPTH = MAX_STATES * SYMBOL_SPAN;
	localparam int TRANS_ABITS = STATE_BITS + COL_BITS;
	localparam int PADDR_BITS  = 4;

	typedef enum logic [2:0] {
		OP_LOAD_TRANS = 3'd0,
		OP_LOAD_ATTR  = 3'd1,
		OP_START      = 3'd2,
		OP_DATA       = 3'd3,
		OP_END        = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		REG_RANGE_LOW     = 2'd0,
		REG_RANGE_HIGH    = 2'd1,
		REG_INITIAL_STATE = 2'd2
	} reg_idx_t;

	// table entry: valid bit on top, target state below
	typedef struct packed {
		logic                  valid;
		logic [STATE_BITS-1:0] target;
	} entry_t;

endpackage
`default_nettype wire

// ===== sv/dfa_longest_match_scanner.sv =====
`default_nettype none
// data byte: the next request waits while a byte is in s1, since the transition memory read feeds the next state
// start: the accepting flag of the initial state is read before the next request
// loads, end and unknown ops: accepted without occupying s1
// result: registered in the cycle after an end request is accepted, or once a byte that hits a dead entry is in s1
// accepting flag of the new state is read in s2, the cycle after s1, and overlaps the next byte
// reset clears control and config registers; table memories stay undefined until loaded
module dfa_longest_match_scanner (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [2:0]                     op,
	input  wire logic [dfa_pkg::STATE_BITS-1:0] state_index,
	input  wire logic [dfa_pkg::SYM_BITS-1:0]   symbol,
	input  wire logic [dfa_pkg::STATE_BITS-1:0] target_state,
	input  wire logic                           target_valid,
	input  wire logic                           final_flag,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                matched,
	output logic [dfa_pkg::LENGTH_BITS-1:0]     match_length,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [dfa_pkg::PADDR_BITS-1:0] paddr,
	input  wire logic [31:0]                    pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	localparam int SB = dfa_pkg::STATE_BITS;
	localparam int LB = dfa_pkg::LENGTH_BITS;
	localparam int CB = dfa_pkg::COL_BITS;
	localparam int YB = dfa_pkg::SYM_BITS;

	// config registers
	logic [YB-1:0] range_low_q, range_high_q;
	logic [SB-1:0] initial_state_q;

	// scan state
	logic [SB-1:0] cur_state_q;
	logic          scanning_q;
	logic [LB-1:0] bytes_q;
	logic [LB-1:0] last_q;
	logic          seen_q;

	// pipeline
	logic s1_valid_q, s1_start_q, s1_in_range_q;
	logic s2_valid_q;

	// output register
	logic          out_valid_q;
	logic          matched_q;
	logic [LB-1:0] match_length_q;

	// memories
	dfa_pkg::entry_t trans_mem [dfa_pkg::TRANS_DEPTH];
	dfa_pkg::entry_t fb_mem [dfa_pkg::MAX_STATES];
	logic            acc_mem [dfa_pkg::MAX_STATES];
	dfa_pkg::entry_t trans_rd_q, fb_rd_q;
	logic            acc_rd_q;

	dfa_pkg::op_t    op_in;
	dfa_pkg::entry_t load_entry, s1_entry;
	logic            in_accept, need_out, out_free;
	logic            in_range, col_ok;
	logic [YB-1:0]   col_full;
	logic [dfa_pkg::TRANS_ABITS-1:0] trans_raddr, trans_waddr;
	logic [SB-1:0]   acc_raddr;
	logic            s1_dead, produce_end, produce_dead;
	logic            cfg_write;
	logic [1:0]      cfg_idx;

	assign op_in     = dfa_pkg::op_t'(op);
	assign out_free  = !out_valid_q || out_ready;
	assign need_out  = scanning_q && (op_in == dfa_pkg::OP_DATA || op_in == dfa_pkg::OP_END);
	assign in_ready  = !s1_valid_q && (!need_out || out_free);
	assign in_accept = in_valid && in_ready;

	assign load_entry = '{valid: target_valid, target: target_state};

	assign col_full = symbol - range_low_q;
	assign col_ok   = {1'b0, col_full} < (YB+1)'(dfa_pkg::SYMBOL_SPAN);
	assign in_range = (symbol >= range_low_q) && (symbol <= range_high_q) && col_ok;
	assign trans_raddr = {cur_state_q, col_full[CB-1:0]};
	assign trans_waddr = {state_index, symbol[CB-1:0]};

	assign s1_entry = s1_in_range_q ? trans_rd_q : fb_rd_q;
	assign s1_dead  = !s1_entry.valid ||
		({1'b0, s1_entry.target} >= (SB+1)'(dfa_pkg::MAX_STATES));
	// next state's flag while a byte is in s1, otherwise the initial state for a start
	assign acc_raddr = s1_valid_q ? s1_entry.target : initial_state_q;

	assign produce_end  = in_accept && op_in == dfa_pkg::OP_END && scanning_q;
	assign produce_dead = s1_valid_q && !s1_start_q && s1_dead;

	always_ff @(posedge clk) begin
		if (in_accept && op_in == dfa_pkg::OP_LOAD_TRANS &&
				{1'b0, symbol} < (YB+1)'(dfa_pkg::SYMBOL_SPAN))
			trans_mem[trans_waddr] <= load_entry;
		trans_rd_q <= trans_mem[trans_raddr];
	end

	always_ff @(posedge clk) begin
		if (in_accept && op_in == dfa_pkg::OP_LOAD_ATTR) begin
			fb_mem[state_index]  <= load_entry;
			acc_mem[state_index] <= final_flag;
		end
		fb_rd_q  <= fb_mem[cur_state_q];
		acc_rd_q <= acc_mem[acc_raddr];
	end

	// config port
	assign pready    = 1'b1;
	assign cfg_idx   = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		case (dfa_pkg::reg_idx_t'(cfg_idx))
			dfa_pkg::REG_RANGE_LOW:     prdata = 32'(range_low_q);
			dfa_pkg::REG_RANGE_HIGH:    prdata = 32'(range_high_q);
			dfa_pkg::REG_INITIAL_STATE: prdata = 32'(initial_state_q);
			default:                    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q     <= '0;
			range_high_q    <= '1;
			initial_state_q <= '0;
		end else if (cfg_write) begin
			case (dfa_pkg::reg_idx_t'(cfg_idx))
				dfa_pkg::REG_RANGE_LOW:     range_low_q     <= pwdata[YB-1:0];
				dfa_pkg::REG_RANGE_HIGH:    range_high_q    <= pwdata[YB-1:0];
				dfa_pkg::REG_INITIAL_STATE: initial_state_q <= pwdata[SB-1:0];
				default: ;
			endcase
		end
	end

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_state_q   <= '0;
			scanning_q    <= 1'b0;
			bytes_q       <= '0;
			last_q        <= '0;
			seen_q        <= 1'b0;
			s1_valid_q    <= 1'b0;
			s1_start_q    <= 1'b0;
			s1_in_range_q <= 1'b0;
			s2_valid_q    <= 1'b0;
		end else begin
			s2_valid_q <= 1'b0;
			s1_valid_q <= 1'b0;

			// accepting flag of the state entered by the previous byte
			if (s2_valid_q && acc_rd_q) begin
				seen_q <= 1'b1;
				last_q <= bytes_q;
			end

			if (s1_valid_q) begin
				if (s1_start_q) begin
					seen_q <= acc_rd_q;
				end else if (s1_dead) begin
					scanning_q <= 1'b0;
				end else begin
					cur_state_q <= s1_entry.target;
					if (bytes_q != '1)
						bytes_q <= bytes_q + LB'(1);
					s2_valid_q <= 1'b1;
				end
			end

			if (in_accept) begin
				case (op_in)
					dfa_pkg::OP_START: begin
						cur_state_q <= initial_state_q;
						scanning_q  <= 1'b1;
						bytes_q     <= '0;
						last_q      <= '0;
						s1_valid_q  <= 1'b1;
						s1_start_q  <= 1'b1;
					end
					dfa_pkg::OP_DATA: begin
						if (scanning_q) begin
							s1_valid_q    <= 1'b1;
							s1_start_q    <= 1'b0;
							s1_in_range_q <= in_range;
						end
					end
					dfa_pkg::OP_END: begin
						scanning_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	// an end request may land while the last byte's flag is still in s2
	logic          seen_eff;
	logic [LB-1:0] last_eff;
	assign seen_eff = seen_q || (s2_valid_q && acc_rd_q);
	assign last_eff = (s2_valid_q && acc_rd_q) ? bytes_q : last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (produce_end || produce_dead)
				out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (produce_end) begin
			matched_q      <= seen_eff;
			match_length_q <= seen_eff ? last_eff : '0;
		end else if (produce_dead) begin
			matched_q      <= seen_q;
			match_length_q <= seen_q ? last_q : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign matched      = matched_q;
	assign match_length = match_length_q;

	a_s1_single: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |=> !s1_valid_q)
		else $error("s1 occupied two cycles in a row");

	a_s2_follows_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q |-> $past(s1_valid_q) && !$past(s1_start_q))
		else $error("s2 without a byte in s1");

	a_dead_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_start_q) |-> !out_valid_q)
		else $error("result slot busy while a byte may end the scan");

	a_s2_scanning: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q |-> scanning_q)
		else $error("flag update outside a scan");

	a_no_double_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(produce_end && produce_dead))
		else $error("two results in one cycle");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none
module tb;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 50;
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [2:0]                     op;
		logic [dfa_pkg::STATE_BITS-1:0] state_index;
		logic [dfa_pkg::SYM_BITS-1:0]   symbol;
		logic [dfa_pkg::STATE_BITS-1:0] target_state;
		logic                           target_valid;
		logic                           final_flag;
	} scan_req_t;

	typedef struct packed {
		logic                            matched;
		logic [dfa_pkg::LENGTH_BITS-1:0] match_len;
	} scan_result_t;

	class scan_scoreboard;
		dfa_pkg::entry_t                 trans_tbl [dfa_pkg::TRANS_DEPTH];
		bit                              trans_written [dfa_pkg::TRANS_DEPTH];
		dfa_pkg::entry_t                 fallback_tbl [dfa_pkg::MAX_STATES];
		bit                              accept_tbl [dfa_pkg::MAX_STATES];
		logic [dfa_pkg::STATE_BITS-1:0]  cur_state;
		bit                              scanning;
		logic [dfa_pkg::LENGTH_BITS-1:0] consumed;
		logic [dfa_pkg::LENGTH_BITS-1:0] last_accept;
		bit                              seen_accept;
		logic [dfa_pkg::SYM_BITS-1:0]    range_low = 8'd0;
		logic [dfa_pkg::SYM_BITS-1:0]    range_high = 8'd255;
		logic [dfa_pkg::STATE_BITS-1:0]  init_state = '0;
		scan_result_t                    pending_matches [$];
		int                              errors;

		function void set_register(dfa_pkg::reg_idx_t idx, bit [31:0] value);
			case (idx)
				dfa_pkg::REG_RANGE_LOW: range_low = value[dfa_pkg::SYM_BITS-1:0];
				dfa_pkg::REG_RANGE_HIGH: range_high = value[dfa_pkg::SYM_BITS-1:0];
				dfa_pkg::REG_INITIAL_STATE: init_state = value[dfa_pkg::STATE_BITS-1:0];
				default: ;
			endcase
		endfunction

		function bit [31:0] register_value(dfa_pkg::reg_idx_t idx);
			case (idx)
				dfa_pkg::REG_RANGE_LOW: return 32'(range_low);
				dfa_pkg::REG_RANGE_HIGH: return 32'(range_high);
				dfa_pkg::REG_INITIAL_STATE: return 32'(init_state);
				default: return '0;
			endcase
		endfunction

		function void end_scan();
			scan_result_t res;
			res.matched = seen_accept;
			res.match_len = seen_accept ? last_accept : '0;
			pending_matches.push_back(res);
			scanning = 0;
		endfunction

		// advance the scanner by one accepted request
		function void note_request(scan_req_t r);
			dfa_pkg::entry_t e;
			e = dfa_pkg::entry_t'({r.target_valid, r.target_state});
			if (r.op == dfa_pkg::OP_LOAD_TRANS) begin
				trans_tbl[{r.state_index, r.symbol}] = e;
				trans_written[{r.state_index, r.symbol}] = 1;
			end else if (r.op == dfa_pkg::OP_LOAD_ATTR) begin
				fallback_tbl[r.state_index] = e;
				accept_tbl[r.state_index] = r.final_flag;
			end else if (r.op == dfa_pkg::OP_START) begin
				cur_state = init_state;
				scanning = 1;
				consumed = '0;
				last_accept = '0;
				seen_accept = accept_tbl[init_state];
			end else if (r.op == dfa_pkg::OP_DATA && scanning) begin
				if (r.symbol >= range_low && r.symbol <= range_high)
					e = trans_tbl[{cur_state, r.symbol - range_low}];
				else
					e = fallback_tbl[cur_state];
				if (!e.valid) begin
					end_scan();
				end else begin
					cur_state = e.target;
					if (consumed != '1)
						consumed = consumed + 1'b1;
					if (accept_tbl[cur_state]) begin
						seen_accept = 1;
						last_accept = consumed;
					end
				end
			end else if (r.op == dfa_pkg::OP_END && scanning) begin
				end_scan();
			end
		endfunction

		function void check_result(logic m, logic [dfa_pkg::LENGTH_BITS-1:0] len);
			scan_result_t exp_res;
			if (pending_matches.size() == 0) begin
				$display("%0t: result with none expected: matched %0b match_length %0d",
					$time, m, len);
				errors++;
				return;
			end
			exp_res = pending_matches.pop_front();
			if (m !== exp_res.matched) begin
				$display("%0t: matched expected %0b actual %0b", $time, exp_res.matched, m);
				errors++;
			end
			if (len !== exp_res.match_len) begin
				$display("%0t: match_length expected %0d actual %0d",
					$time, exp_res.match_len, len);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [2:0] op;
	logic [dfa_pkg::STATE_BITS-1:0] state_index;
	logic [dfa_pkg::SYM_BITS-1:0] symbol;
	logic [dfa_pkg::STATE_BITS-1:0] target_state;
	logic target_valid;
	logic final_flag;
	logic out_valid;
	logic out_ready;
	logic matched;
	logic [dfa_pkg::LENGTH_BITS-1:0] match_length;
	logic psel;
	logic penable;
	logic pwrite;
	logic [dfa_pkg::PADDR_BITS-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	scan_scoreboard sb = new();
	bit quiet;
	bit stall_long;
	int work_items;
	int cycle_count;

	dfa_longest_match_scanner u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.state_index(state_index),
		.symbol(symbol),
		.target_state(target_state),
		.target_valid(target_valid),
		.final_flag(final_flag),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.matched(matched),
		.match_length(match_length),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(matched, match_length);
	end

	// result side: short random stalls, one long hold when asked
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_long) begin
				stall_long = 0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic scan_req_t random_fields();
		scan_req_t r;
		r.op = 3'($urandom_range(0, 7));
		r.state_index = dfa_pkg::STATE_BITS'($urandom_range(0, dfa_pkg::MAX_STATES - 1));
		r.symbol = dfa_pkg::SYM_BITS'($urandom_range(0, 255));
		r.target_state = dfa_pkg::STATE_BITS'($urandom_range(0, dfa_pkg::MAX_STATES - 1));
		r.target_valid = 1'($urandom_range(0, 1));
		r.final_flag = 1'($urandom_range(0, 1));
		return r;
	endfunction

	function automatic scan_req_t mk(logic [2:0] o, logic [dfa_pkg::STATE_BITS-1:0] s,
			logic [dfa_pkg::SYM_BITS-1:0] sym, logic [dfa_pkg::STATE_BITS-1:0] t,
			logic tv, logic f);
		scan_req_t r;
		r.op = o;
		r.state_index = s;
		r.symbol = sym;
		r.target_state = t;
		r.target_valid = tv;
		r.final_flag = f;
		return r;
	endfunction

	task automatic send(scan_req_t r);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		op <= r.op;
		state_index <= r.state_index;
		symbol <= r.symbol;
		target_state <= r.target_state;
		target_valid <= r.target_valid;
		final_flag <= r.final_flag;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (r.op <= dfa_pkg::OP_LOAD_ATTR || r.op == dfa_pkg::OP_START ||
				((r.op == dfa_pkg::OP_DATA || r.op == dfa_pkg::OP_END) && sb.scanning))
			work_items++;
		sb.note_request(r);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_matches.size() != 0) @(negedge clk);
		// loads and dropped bytes leave no result to wait on
		repeat (6) @(negedge clk);
	endtask

	task automatic write_register(dfa_pkg::reg_idx_t idx, bit [31:0] value);
		bit [31:0] readback;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= dfa_pkg::PADDR_BITS'({idx, 2'b00});
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(idx, value);
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (readback !== sb.register_value(idx)) begin
			$display("%0t: register %0d readback expected %0h actual %0h",
				$time, idx, sb.register_value(idx), readback);
			sb.errors++;
		end
	endtask

	// next byte of a scan, loading its table entry first when still unwritten
	task automatic scan_byte();
		scan_req_t r;
		bit has_range;
		bit full;
		int width;
		logic [dfa_pkg::SYM_BITS-1:0] sym;
		logic [dfa_pkg::SYM_BITS-1:0] col;
		has_range = sb.range_low <= sb.range_high;
		full = has_range && sb.range_low == 8'd0 && sb.range_high == 8'd255;
		width = int'(sb.range_high) - int'(sb.range_low);
		if (has_range && (full || $urandom_range(0, 4) != 0)) begin
			if ($urandom_range(0, 1))
				sym = sb.range_low +
					dfa_pkg::SYM_BITS'($urandom_range(0, width < 3 ? width : 3));
			else
				sym = dfa_pkg::SYM_BITS'($urandom_range(sb.range_low, sb.range_high));
			col = sym - sb.range_low;
			if (!sb.trans_written[{sb.cur_state, col}]) begin
				r = random_fields();
				r.op = dfa_pkg::OP_LOAD_TRANS;
				r.state_index = sb.cur_state;
				r.symbol = col;
				r.target_valid = $urandom_range(0, 9) != 0;
				send(r);
			end
		end else begin
			do sym = dfa_pkg::SYM_BITS'($urandom_range(0, 255));
			while (has_range && sym >= sb.range_low && sym <= sb.range_high);
		end
		r = random_fields();
		r.op = dfa_pkg::OP_DATA;
		r.symbol = sym;
		send(r);
	endtask

	task automatic random_request();
		scan_req_t r;
		int pick;
		r = random_fields();
		pick = $urandom_range(0, 99);
		if (sb.scanning && pick < 78) begin
			scan_byte();
			return;
		end
		if (!sb.scanning) begin
			if (pick < 65) r.op = dfa_pkg::OP_START;
			else if (pick < 75) r.op = dfa_pkg::OP_LOAD_TRANS;
			else if (pick < 80) r.op = dfa_pkg::OP_LOAD_ATTR;
			else if (pick < 87) r.op = dfa_pkg::OP_DATA;
			else if (pick < 94) r.op = dfa_pkg::OP_END;
			else r.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
		end else begin
			if (pick < 88) r.op = dfa_pkg::OP_END;
			else if (pick < 92) r.op = dfa_pkg::OP_START;
			else if (pick < 96) r.op = dfa_pkg::OP_LOAD_TRANS;
			else if (pick < 98) r.op = dfa_pkg::OP_LOAD_ATTR;
			else r.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
		end
		if (r.op == dfa_pkg::OP_LOAD_ATTR)
			r.final_flag = $urandom_range(0, 9) < 3;
		send(r);
	endtask

	initial begin
		logic [dfa_pkg::SYM_BITS-1:0] lows [6];
		logic [dfa_pkg::SYM_BITS-1:0] highs [6];
		logic [dfa_pkg::STATE_BITS-1:0] inits [6];
		bit held;
		lows = '{8'd32, 8'd200, 8'd255, 8'd0, 8'd0, 8'd0};
		highs = '{8'd126, 8'd50, 8'd255, 8'd0, 8'd255, 8'd0};
		inits = '{6'd17, 6'd42, 6'd63, 6'd0, 6'd33, 6'd0};
		held = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = dfa_pkg::OP_START;
		state_index = '0;
		symbol = '0;
		target_state = '0;
		target_valid = 1'b0;
		final_flag = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		write_register(dfa_pkg::REG_RANGE_LOW, 32'd0);
		write_register(dfa_pkg::REG_RANGE_HIGH, 32'd255);
		write_register(dfa_pkg::REG_INITIAL_STATE, 32'd0);

		// requests that do nothing while no scan runs
		send(mk(dfa_pkg::OP_DATA, 6'd0, 8'h55, 6'd0, 1'b0, 1'b0));
		send(mk(dfa_pkg::OP_END, 6'd0, 8'h00, 6'd0, 1'b0, 1'b0));
		for (int u = OP_UNUSED_LO; u <= OP_UNUSED_HI; u++)
			send(mk(3'(u), 6'h3F, 8'hFF, 6'h3F, 1'b1, 1'b1));
		send(mk(dfa_pkg::OP_LOAD_ATTR, 6'd0, 8'h00, 6'd1, 1'b1, 1'b0));
		send(mk(dfa_pkg::OP_LOAD_ATTR, 6'd63, 8'h00, 6'd63, 1'b1, 1'b1));
		send(mk(dfa_pkg::OP_LOAD_TRANS, 6'd0, 8'hFF, 6'd63, 1'b1, 1'b0));
		send(mk(dfa_pkg::OP_LOAD_TRANS, 6'd63, 8'h00, 6'd0, 1'b1, 1'b0));
		send(mk(dfa_pkg::OP_LOAD_TRANS, 6'd63, 8'h80, 6'h2A, 1'b0, 1'b0));
		send(mk(dfa_pkg::OP_START, 6'd0, 8'h00, 6'd0, 1'b0, 1'b0));
		send(mk(dfa_pkg::OP_END, 6'd0, 8'h00, 6'd0, 1'b0, 1'b0));
		send(mk(dfa_pkg::OP_START, 6'd0, 8'h00, 6'd0, 1'b0, 1'b0));
		send(mk(dfa_pkg::OP_DATA, 6'd0, 8'hFF, 6'd0, 1'b0, 1'b0));
		send(mk(dfa_pkg::OP_DATA, 6'd0, 8'h00, 6'd0, 1'b0, 1'b0));
		send(mk(dfa_pkg::OP_DATA, 6'd0, 8'hFF, 6'd0, 1'b0, 1'b0));
		// dead entry ends the scan, the byte after it is dropped
		send(mk(dfa_pkg::OP_DATA, 6'd0, 8'h80, 6'd0, 1'b0, 1'b0));
		send(mk(dfa_pkg::OP_DATA, 6'd0, 8'hFF, 6'd0, 1'b0, 1'b0));
		// restart drops the running scan
		send(mk(dfa_pkg::OP_START, 6'd0, 8'h00, 6'd0, 1'b0, 1'b0));
		send(mk(dfa_pkg::OP_DATA, 6'd0, 8'hFF, 6'd0, 1'b0, 1'b0));
		send(mk(dfa_pkg::OP_START, 6'd0, 8'h00, 6'd0, 1'b0, 1'b0));
		send(mk(dfa_pkg::OP_DATA, 6'd0, 8'hFF, 6'd0, 1'b0, 1'b0));
		send(mk(dfa_pkg::OP_END, 6'd0, 8'h00, 6'd0, 1'b0, 1'b0));

		// fallback and accepting flag for every state
		for (int s = 0; s < dfa_pkg::MAX_STATES; s++)
			send(mk(dfa_pkg::OP_LOAD_ATTR, dfa_pkg::STATE_BITS'(s),
				dfa_pkg::SYM_BITS'($urandom_range(0, 255)),
				dfa_pkg::STATE_BITS'($urandom_range(0, dfa_pkg::MAX_STATES - 1)),
				$urandom_range(0, 9) < 7, $urandom_range(0, 9) < 3));

		work_items = 0;
		lows[5] = dfa_pkg::SYM_BITS'($urandom_range(0, 255));
		highs[5] = dfa_pkg::SYM_BITS'($urandom_range(0, 255));
		inits[5] = dfa_pkg::STATE_BITS'($urandom_range(0, dfa_pkg::MAX_STATES - 1));
		for (int p = 0; p < 6; p++) begin
			drain();
			write_register(dfa_pkg::REG_RANGE_LOW, 32'(lows[p]));
			write_register(dfa_pkg::REG_RANGE_HIGH, 32'(highs[p]));
			write_register(dfa_pkg::REG_INITIAL_STATE, 32'(inits[p]));
			if (p == 5)
				quiet = 1;
			while (work_items < PHASE_ITEMS * (p + 1)) begin
				// long hold on the result side while requests keep coming
				if (p == 0 && work_items >= 30 && !held) begin
					stall_long = 1;
					held = 1;
				end
				random_request();
			end
		end

		drain();
		repeat (20) @(negedge clk);
		if (sb.errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
`default_nettype wire
